@@ src/lzmp_pkg.sv @@
// package for the lateral zmp unit: widths, register codes, sequencer states
// and sensor layout tables; no dependencies
package lzmp_pkg;

  localparam int SensorCount = 8;
  localparam int SampleBits  = 16;
  localparam int FracBits    = 12;
  localparam int OffsetW     = 16;
  localparam int RatioW      = 16;
  localparam int QuotBits    = 16;
  localparam int IdxW        = $clog2(SensorCount);
  localparam int TotalW      = RatioW + IdxW;
  localparam int ProdW       = RatioW + OffsetW;
  localparam int RemW        = TotalW + QuotBits - 1;
  localparam int AccW        = RemW;
  localparam int ZmpW        = 17;
  localparam int AddrW       = 4;
  localparam int DataW       = 32;
  localparam int InDataW     = SensorCount * SampleBits;
  localparam int OutDataW    = ((2 * ZmpW + 7) / 8) * 8;

  localparam logic [SampleBits-1:0] PeakReset   = SampleBits'(410);
  localparam logic [OffsetW-1:0]    OuterReset  = 16'd5243;
  localparam logic [OffsetW-1:0]    InnerReset  = 16'd1966;
  localparam logic [SampleBits-1:0] CapReset    = SampleBits'(20480);
  localparam logic [RatioW-1:0]     RatioMax    = '1;

  // bit i set: sensor i is outer / on the left foot
  localparam logic [SensorCount-1:0] SensorIsOuter = 8'b1010_0101;
  localparam logic [SensorCount-1:0] SensorIsLeft  = 8'b0000_1111;

  typedef enum logic [1:0] {
    REG_OUTER = 2'd0,
    REG_INNER = 2'd1,
    REG_CAP   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEAK,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_FSETUP,
    ST_FDIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [OffsetW-1:0]    outer_offset;
    logic [OffsetW-1:0]    inner_offset;
    logic [SampleBits-1:0] peak_cap;
  } cfg_t;

endpackage

@@ src/lateral_zmp_from_foot_forces_unit.sv @@
// top level of the lateral zmp unit: sequencer, peak store, accumulators
// and output register; uses lzmp_apb, lzmp_div and lzmp_pkg
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: eight 16-bit forces
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: zmp_lateral, zmp_previous; tuser: zmp_valid
// apb       in   psel/penable/pwrite, pready   three 16-bit registers at 0x0, 0x4, 0x8
//
// an item runs the peak, divide, multiply and accumulate steps for each sensor and then
// the final division, on the one-bit-per-cycle shared divider used nine times at most
// a saturated or zero-peak ratio skips its division
// s_axis_tready is high only in idle; a full output register holds the sequencer
// reset restores peaks to 0.1 kg, the stored point to zero and the registers
module lateral_zmp_from_foot_forces_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // fields from bit 0: left_front_left, left_front_right, left_rear_left,
  // left_rear_right, right_front_left, right_front_right, right_rear_left,
  // right_rear_right force
  input  logic [lzmp_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // fields from bit 0: zmp_lateral, zmp_previous, zero fill
  output logic [lzmp_pkg::OutDataW-1:0] m_axis_tdata,
  // fields from bit 0: zmp_valid
  output logic                          m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lzmp_pkg::AddrW-1:0]    paddr,
  input  logic [lzmp_pkg::DataW-1:0]    pwdata,
  output logic [lzmp_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import lzmp_pkg::*;

  cfg_t                  cfg;
  state_e                state_q, state_d;
  logic [SampleBits-1:0] samp_q [SensorCount];
  logic [SampleBits-1:0] samp_d [SensorCount];
  logic [SampleBits-1:0] peak_q [SensorCount];
  logic [SampleBits-1:0] peak_d [SensorCount];
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [RatioW-1:0]     ratio_q, ratio_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic [TotalW-1:0]     total_q, total_d;
  logic [AccW-1:0]       pos_q, pos_d, neg_q, neg_d;
  logic                  sign_q, sign_d;
  logic [ZmpW-1:0]       res_q, res_d;
  logic                  resv_q, resv_d;
  logic [ZmpW-1:0]       cur_q, cur_d;
  logic                  mval_q, mval_d;
  logic [ZmpW-1:0]       olat_q, olat_d, oprev_q, oprev_d;
  logic                  oflag_q, oflag_d;

  logic                  div_start, div_done;
  logic [RemW-1:0]       div_dividend;
  logic [TotalW-1:0]     div_divisor;
  logic [QuotBits-1:0]   div_quot;

  logic [SampleBits-1:0] s_cur, p_old, p_new;
  logic [OffsetW-1:0]    offset;
  logic                  out_free;

  lzmp_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lzmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign s_cur    = samp_q[idx_q];
  assign p_old    = peak_q[idx_q];
  assign p_new    = (p_old < s_cur && p_old < cfg.peak_cap) ? s_cur : p_old;
  assign offset   = SensorIsOuter[idx_q] ? cfg.outer_offset : cfg.inner_offset;
  assign out_free = !mval_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = OutDataW'({oprev_q, olat_q});
  assign m_axis_tuser  = oflag_q;

  always_comb begin
    state_d      = state_q;
    samp_d       = samp_q;
    peak_d       = peak_q;
    idx_d        = idx_q;
    ratio_d      = ratio_q;
    prod_d       = prod_q;
    total_d      = total_q;
    pos_d        = pos_q;
    neg_d        = neg_q;
    sign_d       = sign_q;
    res_d        = res_q;
    resv_d       = resv_q;
    cur_d        = cur_q;
    mval_d       = mval_q && !m_axis_tready;
    olat_d       = olat_q;
    oprev_d      = oprev_q;
    oflag_d      = oflag_q;
    div_start    = 1'b0;
    div_dividend = RemW'({s_cur, FracBits'(0)});
    div_divisor  = TotalW'(p_new);

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < SensorCount; i++) begin
            samp_d[i] = s_axis_tdata[i*SampleBits +: SampleBits];
          end
          idx_d   = '0;
          total_d = '0;
          pos_d   = '0;
          neg_d   = '0;
          state_d = ST_PEAK;
        end
      end
      ST_PEAK: begin
        peak_d[idx_q] = p_new;
        if (p_new == '0) begin
          ratio_d = '0;
          state_d = ST_MUL;
        end else if ((SampleBits+4)'(s_cur) >= {p_new, 4'b0}) begin
          ratio_d = RatioMax;
          state_d = ST_MUL;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ratio_d = div_quot;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = ProdW'(ratio_q) * ProdW'(offset);
        total_d = total_q + TotalW'(ratio_q);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (SensorIsLeft[idx_q]) begin
          pos_d = pos_q + AccW'(prod_q);
        end else begin
          neg_d = neg_q + AccW'(prod_q);
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(SensorCount - 1)) begin
          state_d = ST_FSETUP;
        end else begin
          state_d = ST_PEAK;
        end
      end
      ST_FSETUP: begin
        div_divisor = total_q;
        sign_d      = neg_q > pos_q;
        div_dividend = (neg_q > pos_q) ? neg_q - pos_q : pos_q - neg_q;
        if (total_q == '0) begin
          res_d   = '0;
          resv_d  = 1'b0;
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_FDIV;
        end
      end
      ST_FDIV: begin
        if (div_done) begin
          res_d   = sign_q ? -ZmpW'(div_quot) : ZmpW'(div_quot);
          resv_d  = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          mval_d  = 1'b1;
          olat_d  = res_q;
          oprev_d = cur_q;
          oflag_d = resv_q;
          cur_d   = res_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mval_q  <= 1'b0;
      cur_q   <= '0;
      idx_q   <= '0;
      for (int i = 0; i < SensorCount; i++) begin
        peak_q[i] <= PeakReset;
      end
    end else begin
      state_q <= state_d;
      mval_q  <= mval_d;
      cur_q   <= cur_d;
      idx_q   <= idx_d;
      peak_q  <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q  <= samp_d;
    ratio_q <= ratio_d;
    prod_q  <= prod_d;
    total_q <= total_d;
    pos_q   <= pos_d;
    neg_q   <= neg_d;
    sign_q  <= sign_d;
    res_q   <= res_d;
    resv_q  <= resv_d;
    olat_q  <= olat_d;
    oprev_q <= oprev_d;
    oflag_q <= oflag_d;
  end

endmodule

@@ src/lzmp_apb.sv @@
// configuration registers behind an apb-style port
// depends on lzmp_pkg
module lzmp_apb (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lzmp_pkg::AddrW-1:0]  paddr,
  input  logic [lzmp_pkg::DataW-1:0]  pwdata,
  output logic [lzmp_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output lzmp_pkg::cfg_t              cfg_o
);
  import lzmp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_OUTER: cfg_d.outer_offset = pwdata[OffsetW-1:0];
        REG_INNER: cfg_d.inner_offset = pwdata[OffsetW-1:0];
        REG_CAP:   cfg_d.peak_cap     = pwdata[SampleBits-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OUTER: prdata = DataW'(cfg_q.outer_offset);
      REG_INNER: prdata = DataW'(cfg_q.inner_offset);
      REG_CAP:   prdata = DataW'(cfg_q.peak_cap);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.outer_offset <= OuterReset;
      cfg_q.inner_offset <= InnerReset;
      cfg_q.peak_cap     <= CapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ src/lzmp_div.sv @@
// shared restoring divider, one quotient bit per cycle
// quotient must fit QuotBits; depends on lzmp_pkg
module lzmp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lzmp_pkg::RemW-1:0]     dividend_i,
  input  logic [lzmp_pkg::TotalW-1:0]   divisor_i,
  output logic                          done_o,
  output logic [lzmp_pkg::QuotBits-1:0] quotient_o
);
  import lzmp_pkg::*;

  localparam int CntW = $clog2(QuotBits);

  logic [RemW-1:0]     rem_q, rem_d;
  logic [RemW-1:0]     dsh_q, dsh_d;
  logic [QuotBits-1:0] quo_q, quo_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                run_q, run_d;
  logic                done_q, done_d;
  logic                fits;

  assign fits       = rem_q >= dsh_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = dividend_i;
      dsh_d = {divisor_i, (QuotBits-1)'(0)};
      quo_d = '0;
      cnt_d = CntW'(QuotBits - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[QuotBits-2:0], fits};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

endmodule
